/* hdl/sic_pkg.sv */
// Shared constants for the segment intersection core.
// Used by sic_mul and segment_intersection_core; no dependencies.
package sic_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  // Multiplier digit size and stage count
  localparam int MUL_DIGIT = 32;
  localparam int MUL_LAT   = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int THR_W      = 32;
  localparam int MARGIN_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SINE_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MARGIN = 2'd1;

  localparam logic [THR_W-1:0]    THR_RESET    = 32'd4295;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd7;

endpackage

/* hdl/sic_mul.sv */
// Pipelined signed multiplier built from MUL_DIGIT x MUL_DIGIT partial products.
// Depends on sic_pkg; one product per cycle.
module sic_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  import sic_pkg::*;

  localparam int NA  = (AW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int NB  = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int RW  = (NA + 1) * MUL_DIGIT;
  localparam int PW  = (NA + NB) * MUL_DIGIT;
  localparam int PPW = 2 * MUL_DIGIT;

  logic [AW-1:0]           mag_a;
  logic [BW-1:0]           mag_b;
  logic [NA*MUL_DIGIT-1:0] ua_r;
  logic [NB*MUL_DIGIT-1:0] ub_r;
  logic                    neg_r [MUL_LAT-1];
  logic [PPW-1:0]          pp_r  [NA][NB];
  logic [RW-1:0]           row_nxt [NB];
  logic [RW-1:0]           row_r   [NB];
  logic [PW-1:0]           sum_nxt;
  logic [PW-1:0]           sum_r;
  logic [PW-1:0]           sgn;
  logic signed [AW+BW-1:0] p_r;

  // Magnitudes of the operands
  always_comb begin
    mag_a = a[AW-1] ? AW'(-a) : AW'(a);
    mag_b = b[BW-1] ? BW'(-b) : BW'(b);
  end

  // Add partial products of each row, then the rows
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      row_nxt[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_nxt[j] = row_nxt[j] + (RW'(pp_r[i][j]) << (i * MUL_DIGIT));
      end
    end
    sum_nxt = '0;
    for (int j = 0; j < NB; j++) begin
      sum_nxt = sum_nxt + (PW'(row_r[j]) << (j * MUL_DIGIT));
    end
    sgn = neg_r[MUL_LAT-2] ? -sum_r : sum_r;
  end

  always_ff @(posedge clk) begin
    ua_r     <= (NA*MUL_DIGIT)'(mag_a);
    ub_r     <= (NB*MUL_DIGIT)'(mag_b);
    neg_r[0] <= a[AW-1] ^ b[BW-1];
    for (int k = 1; k < MUL_LAT - 1; k++) begin
      neg_r[k] <= neg_r[k-1];
    end
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i][j] <= PPW'(ua_r[i*MUL_DIGIT +: MUL_DIGIT]) *
                      PPW'(ub_r[j*MUL_DIGIT +: MUL_DIGIT]);
      end
    end
    row_r <= row_nxt;
    sum_r <= sum_nxt;
    p_r   <= $signed(sgn[AW+BW-1:0]);
  end

  assign p = p_r;

endmodule

/* hdl/sic_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// No package dependency; an input register is followed by one register per quotient bit, one quotient per cycle.
module sic_div #(
  parameter int NUMW = 100,
  parameter int DENW = 67,
  parameter int QW   = 33
) (
  input  logic            clk,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic [QW-1:0]   q,
  output logic            ovf
);

  localparam int RW = ((NUMW > DENW + QW) ? NUMW : DENW + QW) + 1;

  logic [RW-1:0]   rem_r [QW+1];
  logic [DENW-1:0] den_r [QW+1];
  logic [QW-1:0]   q_r   [QW+1];
  logic            ovf_r [QW+1];
  logic [RW-1:0]   sh    [QW];
  logic            ge    [QW];

  // Trial subtract of the shifted divisor at each stage
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      sh[k] = RW'(den_r[k]) << (QW - 1 - k);
      ge[k] = rem_r[k] >= sh[k];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(num);
    den_r[0] <= den;
    q_r[0]   <= '0;
    ovf_r[0] <= RW'(num) >= (RW'(den) << QW);
    for (int k = 0; k < QW; k++) begin
      rem_r[k+1] <= ge[k] ? rem_r[k] - sh[k] : rem_r[k];
      q_r[k+1]   <= q_r[k] | (ge[k] ? (QW'(1) << (QW - 1 - k)) : QW'(0));
      den_r[k+1] <= den_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  assign q   = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

/* hdl/segment_intersection_core.sv */
// Top level of the segment intersection core: fully pipelined crossing test.
// Depends on sic_pkg, sic_mul and sic_div.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+-------------------------------
//   input   | start, busy, in_*                  | word taken when start & !busy
//   result  | out_valid, out_*                   | one-cycle strobe, no backpressure
//   config  | cfg_valid, cfg_ready, cfg_index,   | word written when valid & ready
//           | cfg_data                           |
//
// One word enters every cycle; busy is never raised.
// The divider, one stage per quotient bit, is the deepest part of the pipeline.
// Reset clears the valid pipeline and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
module segment_intersection_core #(
  parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     in_a_start_x,
  input  logic signed [COORD_WIDTH-1:0]     in_a_start_y,
  input  logic signed [COORD_WIDTH-1:0]     in_a_end_x,
  input  logic signed [COORD_WIDTH-1:0]     in_a_end_y,
  input  logic signed [COORD_WIDTH-1:0]     in_b_start_x,
  input  logic signed [COORD_WIDTH-1:0]     in_b_start_y,
  input  logic signed [COORD_WIDTH-1:0]     in_b_end_x,
  input  logic signed [COORD_WIDTH-1:0]     in_b_end_y,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic                              out_lines_meet,
  output logic signed [COORD_WIDTH-1:0]     out_cross_x,
  output logic signed [COORD_WIDTH-1:0]     out_cross_y,
  output logic                              out_saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sic_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sic_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int D    = W + 1;
  localparam int CRW  = 2 * W + 2;
  localparam int LW   = CRW + 1;
  localparam int BW2  = W + 2;
  localparam int L    = MUL_LAT;
  localparam int QW   = W + 1;
  localparam int NW   = W + CRW + 2;
  localparam int THW  = THR_W + 1;
  localparam int T2W  = 2 * THW;
  localparam int LLW  = 2 * LW;
  localparam int RHW  = T2W + LLW;
  localparam int C2W  = 2 * CRW;
  localparam int CMPW = ((C2W + 64 > RHW) ? C2W + 64 : RHW) + 1;
  localparam int NV   = 8 + 3 * L + QW;

  localparam logic signed [BW2-1:0] HI = BW2'((64'(1) << (W - 1)) - 64'(1));
  localparam logic signed [BW2-1:0] LO = -HI - BW2'(1);

  typedef struct packed {
    logic signed [W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } in_t;

  typedef struct packed {
    logic signed [BW2-1:0] xl, xr, yl, yr;
  } box_t;

  typedef struct packed {
    logic signed [D-1:0] dxa, dya, dxb, dyb, ex, ey;
    logic signed [W-1:0] ax0, ay0;
    box_t                box;
  } s1_t;

  typedef struct packed {
    logic signed [D-1:0] dxa, dya;
    logic signed [W-1:0] ax0, ay0;
    box_t                box;
  } k1_t;

  typedef struct packed {
    logic signed [CRW-1:0] cr, tn;
    logic signed [LW-1:0]  la2, lb2;
    logic signed [D-1:0]   dxa, dya;
    logic signed [W-1:0]   ax0, ay0;
    logic                  deg;
    box_t                  box;
  } s2_t;

  typedef struct packed {
    logic signed [CRW-1:0] cr;
    logic                  z;
    box_t                  box;
  } k2_t;

  typedef struct packed {
    logic signed [C2W-1:0] cr2;
    logic signed [T2W-1:0] thr2;
    logic signed [LLW-1:0] lalb;
    logic signed [NW-1:0]  nx, ny;
    logic signed [CRW-1:0] cr;
    logic                  z;
    box_t                  box;
  } s3_t;

  typedef struct packed {
    logic signed [C2W-1:0] cr2;
    logic signed [NW-1:0]  nx, ny;
    logic signed [CRW-1:0] cr;
    logic                  z;
    box_t                  box;
  } k3_t;

  typedef struct packed {
    logic [NW-1:0]  ax, ay;
    logic [CRW-1:0] acr;
    logic           negx, negy, par;
    box_t           box;
  } s4_t;

  typedef struct packed {
    logic [NW+1:0] mx, my;
    logic [CRW:0]  dd;
    logic          negx, negy, par;
    box_t          box;
  } s5_t;

  typedef struct packed {
    logic negx, negy, par;
    box_t box;
  } k5_t;

  logic [THR_W-1:0]    thr_r;
  logic [MARGIN_W-1:0] margin_r;
  logic                vld_r [NV];
  in_t                 in_r;
  s1_t                 s1_r, s1_nxt;
  k1_t                 c1_r [L];
  s2_t                 s2_r, s2_nxt;
  k2_t                 c2_r [L];
  s3_t                 s3_r, s3_nxt;
  k3_t                 c3_r [L];
  s4_t                 s4_r, s4_nxt;
  s5_t                 s5_r, s5_nxt;
  k5_t                 c5_r [QW+1];

  logic signed [CRW-1:0] p_ab, p_ba, p_aa, p_ay, p_bx, p_by, p_ed, p_fd;
  logic signed [C2W-1:0] m_cr2;
  logic signed [T2W-1:0] m_thr2;
  logic signed [LLW-1:0] m_lalb;
  logic signed [W+CRW-1:0] m_xc, m_yc;
  logic signed [D+CRW-1:0] m_xt, m_yt;
  logic signed [RHW-1:0]   m_rhs;
  logic [QW-1:0]           qx, qy;
  logic                    ovfx, ovfy;

  logic signed [W-1:0]   mina_x, maxa_x, minb_x, maxb_x;
  logic signed [W-1:0]   mina_y, maxa_y, minb_y, maxb_y;
  logic signed [BW2-1:0] pvx, pvy, cx, cy;
  logic                  satx, saty, hit_nxt;

  logic                  out_hit_r, out_meet_r, out_sat_r;
  logic signed [W-1:0]   out_x_r, out_y_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RESET;
      margin_r <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SINE_THR) begin
        thr_r <= cfg_data[THR_W-1:0];
      end else if (cfg_index == CFG_BOX_MARGIN) begin
        margin_r <= cfg_data[MARGIN_W-1:0];
      end
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NV; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
      for (int k = 1; k < NV; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Differences and widened bounding box overlap
  always_comb begin
    mina_x = (in_r.ax0 < in_r.ax1) ? in_r.ax0 : in_r.ax1;
    maxa_x = (in_r.ax0 < in_r.ax1) ? in_r.ax1 : in_r.ax0;
    minb_x = (in_r.bx0 < in_r.bx1) ? in_r.bx0 : in_r.bx1;
    maxb_x = (in_r.bx0 < in_r.bx1) ? in_r.bx1 : in_r.bx0;
    mina_y = (in_r.ay0 < in_r.ay1) ? in_r.ay0 : in_r.ay1;
    maxa_y = (in_r.ay0 < in_r.ay1) ? in_r.ay1 : in_r.ay0;
    minb_y = (in_r.by0 < in_r.by1) ? in_r.by0 : in_r.by1;
    maxb_y = (in_r.by0 < in_r.by1) ? in_r.by1 : in_r.by0;
    s1_nxt.dxa = D'(in_r.ax1) - D'(in_r.ax0);
    s1_nxt.dya = D'(in_r.ay1) - D'(in_r.ay0);
    s1_nxt.dxb = D'(in_r.bx1) - D'(in_r.bx0);
    s1_nxt.dyb = D'(in_r.by1) - D'(in_r.by0);
    s1_nxt.ex  = D'(in_r.bx0) - D'(in_r.ax0);
    s1_nxt.ey  = D'(in_r.by0) - D'(in_r.ay0);
    s1_nxt.ax0 = in_r.ax0;
    s1_nxt.ay0 = in_r.ay0;
    s1_nxt.box.xl = BW2'((mina_x > minb_x) ? mina_x : minb_x) - BW2'(margin_r);
    s1_nxt.box.xr = BW2'((maxa_x < maxb_x) ? maxa_x : maxb_x) + BW2'(margin_r);
    s1_nxt.box.yl = BW2'((mina_y > minb_y) ? mina_y : minb_y) - BW2'(margin_r);
    s1_nxt.box.yr = BW2'((maxa_y < maxb_y) ? maxa_y : maxb_y) + BW2'(margin_r);
  end

  // First products: cross term, squared lengths, crossing numerator
  sic_mul #(.AW(D), .BW(D)) u_mul_ab (.clk, .a(s1_r.dxa), .b(s1_r.dyb), .p(p_ab));
  sic_mul #(.AW(D), .BW(D)) u_mul_ba (.clk, .a(s1_r.dya), .b(s1_r.dxb), .p(p_ba));
  sic_mul #(.AW(D), .BW(D)) u_mul_aa (.clk, .a(s1_r.dxa), .b(s1_r.dxa), .p(p_aa));
  sic_mul #(.AW(D), .BW(D)) u_mul_ay (.clk, .a(s1_r.dya), .b(s1_r.dya), .p(p_ay));
  sic_mul #(.AW(D), .BW(D)) u_mul_bx (.clk, .a(s1_r.dxb), .b(s1_r.dxb), .p(p_bx));
  sic_mul #(.AW(D), .BW(D)) u_mul_by (.clk, .a(s1_r.dyb), .b(s1_r.dyb), .p(p_by));
  sic_mul #(.AW(D), .BW(D)) u_mul_ed (.clk, .a(s1_r.ex),  .b(s1_r.dyb), .p(p_ed));
  sic_mul #(.AW(D), .BW(D)) u_mul_fd (.clk, .a(s1_r.ey),  .b(s1_r.dxb), .p(p_fd));

  // Combine first products
  always_comb begin
    s2_nxt.cr  = p_ab - p_ba;
    s2_nxt.tn  = p_ed - p_fd;
    s2_nxt.la2 = LW'(p_aa) + LW'(p_ay);
    s2_nxt.lb2 = LW'(p_bx) + LW'(p_by);
    s2_nxt.deg = (p_aa == '0 && p_ay == '0) || (p_bx == '0 && p_by == '0);
    s2_nxt.dxa = c1_r[L-1].dxa;
    s2_nxt.dya = c1_r[L-1].dya;
    s2_nxt.ax0 = c1_r[L-1].ax0;
    s2_nxt.ay0 = c1_r[L-1].ay0;
    s2_nxt.box = c1_r[L-1].box;
  end

  // Second products
  sic_mul #(.AW(CRW), .BW(CRW)) u_mul_cr2 (.clk, .a(s2_r.cr), .b(s2_r.cr), .p(m_cr2));
  sic_mul #(.AW(THW), .BW(THW)) u_mul_thr (
    .clk, .a($signed({1'b0, thr_r})), .b($signed({1'b0, thr_r})), .p(m_thr2));
  sic_mul #(.AW(LW), .BW(LW)) u_mul_ll (.clk, .a(s2_r.la2), .b(s2_r.lb2), .p(m_lalb));
  sic_mul #(.AW(W), .BW(CRW)) u_mul_xc (.clk, .a(s2_r.ax0), .b(s2_r.cr), .p(m_xc));
  sic_mul #(.AW(W), .BW(CRW)) u_mul_yc (.clk, .a(s2_r.ay0), .b(s2_r.cr), .p(m_yc));
  sic_mul #(.AW(D), .BW(CRW)) u_mul_xt (.clk, .a(s2_r.dxa), .b(s2_r.tn), .p(m_xt));
  sic_mul #(.AW(D), .BW(CRW)) u_mul_yt (.clk, .a(s2_r.dya), .b(s2_r.tn), .p(m_yt));

  // Crossing numerators
  always_comb begin
    s3_nxt.cr2  = m_cr2;
    s3_nxt.thr2 = m_thr2;
    s3_nxt.lalb = m_lalb;
    s3_nxt.nx   = NW'(m_xc) + NW'(m_xt);
    s3_nxt.ny   = NW'(m_yc) + NW'(m_yt);
    s3_nxt.cr   = c2_r[L-1].cr;
    s3_nxt.z    = c2_r[L-1].z;
    s3_nxt.box  = c2_r[L-1].box;
  end

  // Threshold side of the parallel test
  sic_mul #(.AW(T2W), .BW(LLW)) u_mul_rhs (.clk, .a(s3_r.thr2), .b(s3_r.lalb), .p(m_rhs));

  // Parallel decision and sign normalization
  always_comb begin
    s4_nxt.par  = c3_r[L-1].z ||
                  ((CMPW'(c3_r[L-1].cr2) << 64) < CMPW'(m_rhs));
    s4_nxt.ax   = c3_r[L-1].nx[NW-1] ? NW'(-c3_r[L-1].nx) : NW'(c3_r[L-1].nx);
    s4_nxt.ay   = c3_r[L-1].ny[NW-1] ? NW'(-c3_r[L-1].ny) : NW'(c3_r[L-1].ny);
    s4_nxt.acr  = c3_r[L-1].cr[CRW-1] ? CRW'(-c3_r[L-1].cr) : CRW'(c3_r[L-1].cr);
    s4_nxt.negx = c3_r[L-1].nx[NW-1] ^ c3_r[L-1].cr[CRW-1];
    s4_nxt.negy = c3_r[L-1].ny[NW-1] ^ c3_r[L-1].cr[CRW-1];
    s4_nxt.box  = c3_r[L-1].box;
  end

  // Rounding offsets: quotient of (2|n| + d) by 2d
  always_comb begin
    s5_nxt.mx   = (NW+2)'({s4_r.ax, 1'b0}) + (NW+2)'(s4_r.acr);
    s5_nxt.my   = (NW+2)'({s4_r.ay, 1'b0}) + (NW+2)'(s4_r.acr);
    s5_nxt.dd   = {s4_r.acr, 1'b0};
    s5_nxt.negx = s4_r.negx;
    s5_nxt.negy = s4_r.negy;
    s5_nxt.par  = s4_r.par;
    s5_nxt.box  = s4_r.box;
  end

  sic_div #(.NUMW(NW+2), .DENW(CRW+1), .QW(QW)) u_div_x (
    .clk, .num(s5_r.mx), .den(s5_r.dd), .q(qx), .ovf(ovfx));
  sic_div #(.NUMW(NW+2), .DENW(CRW+1), .QW(QW)) u_div_y (
    .clk, .num(s5_r.my), .den(s5_r.dd), .q(qy), .ovf(ovfy));

  // Signed point, window test and clamp
  always_comb begin
    pvx  = c5_r[QW].negx ? -BW2'(qx) : BW2'(qx);
    pvy  = c5_r[QW].negy ? -BW2'(qy) : BW2'(qy);
    satx = ovfx || pvx > HI || pvx < LO;
    saty = ovfy || pvy > HI || pvy < LO;
    cx   = (ovfx || pvx > HI || pvx < LO) ?
           ((c5_r[QW].negx || (!ovfx && pvx < LO)) ? LO : HI) : pvx;
    cy   = (ovfy || pvy > HI || pvy < LO) ?
           ((c5_r[QW].negy || (!ovfy && pvy < LO)) ? LO : HI) : pvy;
    hit_nxt = !ovfx && !ovfy &&
              c5_r[QW].box.xl <= pvx && pvx <= c5_r[QW].box.xr &&
              c5_r[QW].box.yl <= pvy && pvy <= c5_r[QW].box.yr;
  end

  // Pipeline payload registers
  always_ff @(posedge clk) begin
    in_r <= '{in_a_start_x, in_a_start_y, in_a_end_x, in_a_end_y,
              in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y};
    s1_r <= s1_nxt;
    c1_r[0] <= '{s1_r.dxa, s1_r.dya, s1_r.ax0, s1_r.ay0, s1_r.box};
    for (int k = 1; k < L; k++) c1_r[k] <= c1_r[k-1];
    s2_r <= s2_nxt;
    c2_r[0] <= '{s2_r.cr, s2_r.deg || (s2_r.cr == '0), s2_r.box};
    for (int k = 1; k < L; k++) c2_r[k] <= c2_r[k-1];
    s3_r <= s3_nxt;
    c3_r[0] <= '{s3_r.cr2, s3_r.nx, s3_r.ny, s3_r.cr, s3_r.z, s3_r.box};
    for (int k = 1; k < L; k++) c3_r[k] <= c3_r[k-1];
    s4_r <= s4_nxt;
    s5_r <= s5_nxt;
    c5_r[0] <= '{s5_r.negx, s5_r.negy, s5_r.par, s5_r.box};
    for (int k = 1; k <= QW; k++) c5_r[k] <= c5_r[k-1];
    // Drop everything for parallel or degenerate lines
    out_meet_r <= !c5_r[QW].par;
    out_hit_r  <= !c5_r[QW].par && hit_nxt;
    out_sat_r  <= !c5_r[QW].par && (satx || saty);
    out_x_r    <= c5_r[QW].par ? '0 : cx[W-1:0];
    out_y_r    <= c5_r[QW].par ? '0 : cy[W-1:0];
  end

  assign out_valid      = vld_r[NV-1];
  assign out_hit        = out_hit_r;
  assign out_lines_meet = out_meet_r;
  assign out_cross_x    = out_x_r;
  assign out_cross_y    = out_y_r;
  assign out_saturated  = out_sat_r;

  // Every accepted word yields one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(NV) out_valid)
    else $error("result missing after pipeline latency");

  // A hit needs a real crossing
  a_hit_meet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_lines_meet)
    else $error("hit without crossing");

  // Parallel lines give an all-zero word
  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_lines_meet |->
      out_cross_x == '0 && out_cross_y == '0 && !out_saturated)
    else $error("parallel result not cleared");

  // Clamped point sits at a range limit
  a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_cross_x == HI[W-1:0] || out_cross_x == LO[W-1:0] ||
      out_cross_y == HI[W-1:0] || out_cross_y == LO[W-1:0])
    else $error("saturated point not at a limit");

endmodule
